/* rtl/core/hasa_pkg.sv */
`timescale 1ns / 1ps
package hasa_pkg;

  localparam int TEMP_W    = 24;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 14;
  localparam int OCOL_W    = 10;
  localparam int GW_W      = 11;
  localparam int DT_W      = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DEPTH = 4;
  localparam int MAX_RES   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH,
    REG_GRID_HEIGHT,
    REG_TIME_STEP,
    REG_COND_COEFF
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_ISSUE,
    BK_DRAIN
  } back_state_t;

  typedef logic signed [TEMP_W-1:0] temp_t;

  // Effective geometry and coefficients seen by the datapath
  typedef struct packed {
    logic [COL_W-1:0] width;
    logic [ROW_W-1:0] height;
    logic [DT_W-1:0]  dt;
    logic [DT_W-1:0]  kc;
  } geom_cfg_t;

  // One classified request between front and back
  typedef struct packed {
    temp_t            t;
    temp_t            wx;
    temp_t            wy;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } cell_req_t;

  // One cell update handed to the arithmetic pipe
  typedef struct packed {
    temp_t             ctr;
    temp_t             up;
    temp_t             dn;
    temp_t             lf;
    temp_t             rt;
    temp_t             wx;
    temp_t             wy;
    logic              hu;
    logic              hd;
    logic              hl;
    logic              hr;
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              last;
    logic              fe;
  } cell_job_t;

  typedef struct packed {
    temp_t             new_temp;
    logic [ROW_W-1:0]  cell_row;
    logic [OCOL_W-1:0] cell_col;
    logic              last_of_run;
    logic              frame_end;
  } result_t;

  // Q0.16 reciprocal of the neighbor count
  function automatic logic [16:0] recip_q16(input logic [2:0] cnt);
    logic [16:0] r;
    begin
      case (cnt)
        3'd2:    r = 17'd32768;
        3'd3:    r = 17'd21845;
        3'd4:    r = 17'd16384;
        default: r = 17'd0;
      endcase
      recip_q16 = r;
    end
  endfunction

  // Arithmetic shift right with rounding to nearest, ties away from zero
  function automatic logic signed [63:0] round_sh(input logic signed [63:0] x, input int s);
    logic [63:0] u;
    logic [63:0] r;
    begin
      u = x[63] ? 64'(-x) : 64'(x);
      r = (u + (64'd1 << (s - 1))) >> s;
      round_sh = x[63] ? -signed'(r) : signed'(r);
    end
  endfunction

endpackage

/* rtl/core/hasa_if.sv */
`timescale 1ns / 1ps
interface hasa_in_if import hasa_pkg::*; ();
  logic  valid;
  logic  ready;
  temp_t cell_temp;
  temp_t wind_row_comp;
  temp_t wind_col_comp;

  modport source (output valid, cell_temp, wind_row_comp, wind_col_comp, input ready);
  modport sink (input valid, cell_temp, wind_row_comp, wind_col_comp, output ready);
endinterface

interface hasa_out_if import hasa_pkg::*; ();
  logic              valid;
  logic              ready;
  temp_t             new_temp;
  logic [ROW_W-1:0]  cell_row;
  logic [OCOL_W-1:0] cell_col;
  logic              last_of_run;
  logic              frame_end;

  modport source (output valid, new_temp, cell_row, cell_col, last_of_run, frame_end,
                  input ready);
  modport sink (input valid, new_temp, cell_row, cell_col, last_of_run, frame_end,
                output ready);
endinterface

/* rtl/core/hasa_fifo.sv */
`timescale 1ns / 1ps
module hasa_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [W-1:0]               din,
  input  logic                       pop,
  output logic [W-1:0]               dout,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign dout    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // hold payload
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= din;
  end
endmodule

/* rtl/core/hasa_front.sv */
`timescale 1ns / 1ps
module hasa_front import hasa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  geom_cfg_t cfg,
  input  logic      restart,
  hasa_in_if.sink   in_ch,
  input  logic      q_pop,
  output logic      q_empty,
  output cell_req_t q_req
);
  logic [ROW_W-1:0] row_r, row_nxt, r_cur, r_inc;
  logic [COL_W-1:0] col_r, col_nxt, c_cur, c_inc;
  logic             outside, accept, q_full;
  cell_req_t        req;

  // restart the frame when the counters left the grid
  assign outside = (row_r >= cfg.height) || (col_r >= cfg.width);
  assign r_cur   = outside ? '0 : row_r;
  assign c_cur   = outside ? '0 : col_r;
  assign r_inc   = r_cur + 1'b1;
  assign c_inc   = c_cur + 1'b1;
  assign accept  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !q_full;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (restart) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (accept) begin
      if (c_inc >= cfg.width) begin
        col_nxt = '0;
        row_nxt = (r_inc >= cfg.height) ? '0 : r_inc;
      end else begin
        row_nxt = r_cur;
        col_nxt = c_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // tag the request with its position
  always_comb begin
    req.t   = in_ch.cell_temp;
    req.wx  = in_ch.wind_row_comp;
    req.wy  = in_ch.wind_col_comp;
    req.row = r_cur;
    req.col = c_cur;
  end

  logic [$clog2(3)-1:0] q_cnt;

  hasa_fifo #(.W($bits(cell_req_t)), .DEPTH(2)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .din   (req),
    .pop   (q_pop),
    .dout  (q_req),
    .full  (q_full),
    .empty (q_empty),
    .count (q_cnt)
  );
endmodule

/* rtl/core/hasa_cell.sv */
`timescale 1ns / 1ps
module hasa_cell import hasa_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  geom_cfg_t cfg,
  input  logic      job_valid,
  input  cell_job_t job,
  output logic      res_valid,
  output result_t   res,
  output logic      busy
);
  localparam int D_W    = TEMP_W + 1;
  localparam int SUM_W  = TEMP_W + 3;
  localparam int PM_W   = SUM_W + 18;
  localparam int PX_W   = 2 * D_W;
  localparam int KDT_W  = 2 * DT_W;
  localparam int MEAN_W = 28;
  localparam int PC_W   = MEAN_W + KDT_W + 1;
  localparam int A1_W   = 48;
  localparam int PLO_W  = TEMP_W + DT_W;
  localparam int PHI_W  = (A1_W - TEMP_W) + DT_W + 1;
  localparam int ACC_W  = 48;

  logic signed [D_W-1:0]   d_up, d_dn, d_lf, d_rt, dx, dy;
  logic signed [SUM_W-1:0] sum;
  logic [2:0]              cnt;
  logic [TEMP_W-1:0]       ax, ay;
  temp_t                   nx, ny;

  logic                    v1_r, v2_r, v3_r, v4_r;
  logic signed [PM_W-1:0]  s1_pm_r;
  logic signed [PX_W-1:0]  s1_px_r, s1_py_r;
  logic [KDT_W-1:0]        s1_kdt_r;
  logic                    s1_int_r, s2_int_r;
  temp_t                   s1_ctr_r, s2_ctr_r;
  result_t                 s1_tag_r, s2_tag_r, s3_tag_r;

  logic signed [MEAN_W-1:0] mean;
  logic signed [63:0]       a64;
  logic signed [A1_W-1:0]   a1;
  logic signed [PC_W-1:0]   s2_pc_r;
  logic [PLO_W-1:0]         s2_plo_r;
  logic signed [PHI_W-1:0]  s2_phi_r;

  logic signed [63:0]       advp, cond64, adv64;
  logic signed [ACC_W-1:0]  s3_acc_r;

  // differences, neighbor count and upwind selection
  always_comb begin
    d_up = D_W'(job.ctr) - D_W'(job.up);
    d_dn = D_W'(job.ctr) - D_W'(job.dn);
    d_lf = D_W'(job.ctr) - D_W'(job.lf);
    d_rt = D_W'(job.ctr) - D_W'(job.rt);
    sum  = (job.hu ? SUM_W'(d_up) : '0) + (job.hd ? SUM_W'(d_dn) : '0)
         + (job.hl ? SUM_W'(d_lf) : '0) + (job.hr ? SUM_W'(d_rt) : '0);
    cnt  = 3'(job.hu) + 3'(job.hd) + 3'(job.hl) + 3'(job.hr);
    nx   = (job.wx > 0) ? job.dn : job.up;
    ny   = (job.wy > 0) ? job.rt : job.lf;
    dx   = D_W'(job.ctr) - D_W'(nx);
    dy   = D_W'(job.ctr) - D_W'(ny);
    ax   = job.wx[TEMP_W-1] ? TEMP_W'(-job.wx) : TEMP_W'(job.wx);
    ay   = job.wy[TEMP_W-1] ? TEMP_W'(-job.wy) : TEMP_W'(job.wy);
  end

  // stage 1: mean product, advection products, K*dt
  always_ff @(posedge clk) begin
    s1_pm_r  <= PM_W'(sum * $signed({1'b0, recip_q16(cnt)}));
    s1_px_r  <= PX_W'($signed({1'b0, ax}) * dx);
    s1_py_r  <= PX_W'($signed({1'b0, ay}) * dy);
    s1_kdt_r <= cfg.kc * cfg.dt;
    s1_int_r <= job.hu && job.hd && job.hl && job.hr;
    s1_ctr_r <= job.ctr;
    s1_tag_r <= '{new_temp: '0, cell_row: job.row, cell_col: job.col,
                  last_of_run: job.last, frame_end: job.fe};
  end

  // round the mean, scale the advection sum
  always_comb begin
    mean = MEAN_W'(round_sh(64'(s1_pm_r), 16));
    a64  = -((64'(s1_px_r) + 64'(s1_py_r)) * 64'sd10);
    a1   = A1_W'(round_sh(a64, FRAC_BITS));
  end

  // stage 2: conduction product, advection times dt in two halves
  always_ff @(posedge clk) begin
    s2_pc_r  <= PC_W'(mean * $signed({1'b0, s1_kdt_r}));
    s2_plo_r <= a1[TEMP_W-1:0] * cfg.dt;
    s2_phi_r <= PHI_W'($signed(a1[A1_W-1:TEMP_W]) * $signed({1'b0, cfg.dt}));
    s2_int_r <= s1_int_r;
    s2_ctr_r <= s1_ctr_r;
    s2_tag_r <= s1_tag_r;
  end

  always_comb begin
    cond64 = -round_sh(64'(s2_pc_r), 32);
    advp   = (64'(s2_phi_r) <<< TEMP_W) + signed'(64'(s2_plo_r));
    adv64  = s2_int_r ? round_sh(advp, 16) : 64'sd0;
  end

  // stage 3: accumulate
  always_ff @(posedge clk) begin
    s3_acc_r <= ACC_W'(s2_ctr_r) + ACC_W'(cond64) + ACC_W'(adv64);
    s3_tag_r <= s2_tag_r;
  end

  // stage 4: saturate into the result register
  always_ff @(posedge clk) begin
    res <= s3_tag_r;
    if (s3_acc_r > ACC_W'(signed'(24'sh7FFFFF)))
      res.new_temp <= 24'sh7FFFFF;
    else if (s3_acc_r < ACC_W'(signed'(24'sh800000)))
      res.new_temp <= 24'sh800000;
    else
      res.new_temp <= s3_acc_r[TEMP_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= job_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign res_valid = v4_r;
  assign busy      = v1_r || v2_r || v3_r || v4_r;
endmodule

/* rtl/core/hasa_back.sv */
`timescale 1ns / 1ps
module hasa_back import hasa_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  geom_cfg_t cfg,
  input  logic      q_empty,
  input  cell_req_t q_req,
  output logic      q_pop,
  input  logic      out_room,
  input  logic      cell_busy,
  output logic      job_valid,
  output cell_job_t job
);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [2:0] RD_LAST = 3'd4;

  // line buffers
  temp_t up_mem [MAX_WIDTH];
  temp_t mid_mem [MAX_WIDTH];
  temp_t wx_mem [MAX_WIDTH];
  temp_t wy_mem [MAX_WIDTH];

  back_state_t state_r, state_nxt;
  cell_req_t   req_r;
  logic [2:0]  rd_cnt_r, pend_r, pend_init, pend_clr;
  temp_t       mid_rd_r, up_rd_r, wx_rd_r, wy_rd_r;
  temp_t       mid_c_r, up_c_r, wx_r, wy_r, mid_p1_r, up_m1_r, mid_m1_r, mid_m2_r;
  logic [COL_W-1:0] mid_addr, up_addr;
  logic [1:0]  sel;
  logic        start, rd_done, last_row, at_last_col;
  logic [ROW_W-1:0] r;
  logic [COL_W-1:0] c;

  assign r           = req_r.row;
  assign c           = req_r.col;
  assign start       = !q_empty && out_room;
  assign rd_done     = (rd_cnt_r == RD_LAST);
  assign last_row    = (r == cfg.height - 1'b1);
  assign at_last_col = (c == cfg.width - 1'b1);
  assign pend_init   = {last_row && at_last_col, last_row && (c != '0), r != '0};

  // lowest pending result goes first
  always_comb begin
    if (pend_r[0])      sel = 2'd0;
    else if (pend_r[1]) sel = 2'd1;
    else                sel = 2'd2;
    pend_clr = pend_r & ~(3'b001 << sel);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (start) state_nxt = BK_READ;
      BK_READ:  if (rd_done) state_nxt = (pend_init != '0) ? BK_ISSUE : BK_IDLE;
      BK_ISSUE: if (pend_clr == '0) state_nxt = BK_DRAIN;
      BK_DRAIN: if (!cell_busy) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop     = 1'b0;
    job_valid = 1'b0;
    unique case (state_r)
      BK_IDLE:  q_pop = start;
      BK_ISSUE: job_valid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      rd_cnt_r <= '0;
      pend_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_IDLE) rd_cnt_r <= '0;
      else if (state_r == BK_READ && !rd_done) rd_cnt_r <= rd_cnt_r + 1'b1;
      if (state_r == BK_READ && rd_done) pend_r <= pend_init;
      else if (state_r == BK_ISSUE) pend_r <= pend_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) req_r <= q_req;
  end

  // read sequence: middle at c, c+1, c-1, c-2; upper at c, c-1
  always_comb begin
    case (rd_cnt_r)
      3'd0:    mid_addr = c;
      3'd1:    mid_addr = c + 1'b1;
      3'd2:    mid_addr = c - 1'b1;
      default: mid_addr = c - 2'd2;
    endcase
    up_addr = (rd_cnt_r == 3'd0) ? c : c - 1'b1;
  end

  always_ff @(posedge clk) begin
    mid_rd_r <= mid_mem[mid_addr[AW-1:0]];
    up_rd_r  <= up_mem[up_addr[AW-1:0]];
    wx_rd_r  <= wx_mem[c[AW-1:0]];
    wy_rd_r  <= wy_mem[c[AW-1:0]];
    if (state_r == BK_READ && rd_done) begin
      up_mem[c[AW-1:0]]  <= mid_c_r;
      mid_mem[c[AW-1:0]] <= req_r.t;
      wx_mem[c[AW-1:0]]  <= req_r.wx;
      wy_mem[c[AW-1:0]]  <= req_r.wy;
    end
  end

  // capture the registered read data in the cycle after each address
  always_ff @(posedge clk) begin
    if (state_r == BK_READ) begin
      case (rd_cnt_r)
        3'd1: begin
          mid_c_r <= mid_rd_r;
          up_c_r  <= up_rd_r;
          wx_r    <= wx_rd_r;
          wy_r    <= wy_rd_r;
        end
        3'd2: begin
          mid_p1_r <= mid_rd_r;
          up_m1_r  <= up_rd_r;
        end
        3'd3: mid_m1_r <= mid_rd_r;
        3'd4: mid_m2_r <= mid_rd_r;
        default: ;
      endcase
    end
  end

  // build the selected cell update
  always_comb begin
    job      = '0;
    job.last = (pend_clr == '0);
    case (sel)
      2'd0: begin
        job.ctr = mid_c_r;
        job.up  = up_c_r;
        job.hu  = (r != ROW_W'(1));
        job.dn  = req_r.t;
        job.hd  = 1'b1;
        job.lf  = up_m1_r;
        job.hl  = (c != '0);
        job.rt  = mid_p1_r;
        job.hr  = !at_last_col;
        job.wx  = wx_r;
        job.wy  = wy_r;
        job.row = r - 1'b1;
        job.col = c[OCOL_W-1:0];
      end
      2'd1: begin
        job.ctr = mid_m1_r;
        job.up  = up_m1_r;
        job.hu  = 1'b1;
        job.lf  = mid_m2_r;
        job.hl  = (c != COL_W'(1));
        job.rt  = req_r.t;
        job.hr  = 1'b1;
        job.row = r;
        job.col = OCOL_W'(c - 1'b1);
      end
      default: begin
        job.ctr = req_r.t;
        job.up  = mid_c_r;
        job.hu  = 1'b1;
        job.lf  = mid_m1_r;
        job.hl  = 1'b1;
        job.row = r;
        job.col = c[OCOL_W-1:0];
        job.fe  = 1'b1;
      end
    endcase
  end
endmodule

/* rtl/core/heat_advection_stencil_step.sv */
`timescale 1ns / 1ps
// Heat stencil step: takes grid cells in raster order (temperature and two wind
// components, signed Q8.16) and returns updated temperatures with their row and
// column once the lower neighbor is known; the last row follows one column late
// and the frame's final cell comes right after its own input. Rows zero give no
// result, last-row cells give up to three. Each cell is handled in order: the
// request is taken, the buffers are read (four serial reads of the middle-row
// buffer), each result is issued in turn, and, if any result was issued, the
// four-stage arithmetic pipe drains before the next cell starts. A write to
// grid_width or grid_height restarts the frame; configuration is to be written
// by the user only while the block is idle, which the block itself does not enforce.
module heat_advection_stencil_step import hasa_pkg::*; #(
  parameter int MAX_WIDTH = 1024,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  hasa_in_if.sink              in_ch,
  hasa_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);
  logic [GW_W-1:0]  grid_width_r;
  logic [ROW_W-1:0] grid_height_r;
  logic [DT_W-1:0]  time_step_r, cond_coeff_r;
  logic [COL_W-1:0] gw_ext, eff_w;
  logic [ROW_W-1:0] eff_h;
  logic             restart;
  geom_cfg_t        cfg;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= GW_W'(1024);
      grid_height_r <= ROW_W'(1024);
      time_step_r   <= DT_W'(655);
      cond_coeff_r  <= DT_W'(1593);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_GRID_WIDTH:  grid_width_r  <= cfg_wdata[GW_W-1:0];
        REG_GRID_HEIGHT: grid_height_r <= cfg_wdata[ROW_W-1:0];
        REG_TIME_STEP:   time_step_r   <= cfg_wdata;
        REG_COND_COEFF:  cond_coeff_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign restart = cfg_we && (cfg_reg_t'(cfg_idx) == REG_GRID_WIDTH ||
                              cfg_reg_t'(cfg_idx) == REG_GRID_HEIGHT);

  // clamp geometry
  assign gw_ext = COL_W'(grid_width_r);
  assign eff_w  = (gw_ext < COL_W'(3)) ? COL_W'(3) :
                  (gw_ext > COL_W'(MAX_WIDTH)) ? COL_W'(MAX_WIDTH) : gw_ext;
  assign eff_h  = (grid_height_r < ROW_W'(3)) ? ROW_W'(3) : grid_height_r;

  always_comb begin
    cfg.width  = eff_w;
    cfg.height = eff_h;
    cfg.dt     = time_step_r;
    cfg.kc     = cond_coeff_r;
  end

  logic      q_pop, q_empty, job_valid, cell_busy, res_valid, out_room;
  logic      oq_full, oq_empty;
  cell_req_t q_req;
  cell_job_t job;
  result_t   res, oq_dout;
  logic [$clog2(OUT_DEPTH+1)-1:0] oq_cnt;

  hasa_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .restart (restart),
    .in_ch   (in_ch),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_req   (q_req)
  );

  assign out_room = (oq_cnt <= ($clog2(OUT_DEPTH+1))'(OUT_DEPTH - MAX_RES));

  hasa_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_req     (q_req),
    .q_pop     (q_pop),
    .out_room  (out_room),
    .cell_busy (cell_busy),
    .job_valid (job_valid),
    .job       (job)
  );

  hasa_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .job_valid (job_valid),
    .job       (job),
    .res_valid (res_valid),
    .res       (res),
    .busy      (cell_busy)
  );

  hasa_fifo #(.W($bits(result_t)), .DEPTH(OUT_DEPTH)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .din   (res),
    .pop   (out_ch.valid && out_ch.ready),
    .dout  (oq_dout),
    .full  (oq_full),
    .empty (oq_empty),
    .count (oq_cnt)
  );

  // drive the result channel
  assign out_ch.valid       = !oq_empty;
  assign out_ch.new_temp    = oq_dout.new_temp;
  assign out_ch.cell_row    = oq_dout.cell_row;
  assign out_ch.cell_col    = oq_dout.cell_col;
  assign out_ch.last_of_run = oq_dout.last_of_run;
  assign out_ch.frame_end   = oq_dout.frame_end;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_valid && oq_full))
    else $error("result queue overflow");

  a_fe_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.frame_end) |-> out_ch.last_of_run)
    else $error("frame end without last of run");

  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (oq_cnt <= ($clog2(OUT_DEPTH+1))'(OUT_DEPTH - MAX_RES)) && !cell_busy)
    else $error("cell started without result room");
endmodule
